[design/lqrbc_pkg.sv]
// ----------------------------------------------------------------------------
// LQR balance control package
// Shared widths, register indexes, reset values, config bundle and FSM states.
// ----------------------------------------------------------------------------
package lqrbc_pkg;

  localparam int DATA_W     = 32;
  localparam int ERR_W      = 33;
  localparam int MUL_W      = 33;
  localparam int PROD_W     = 2 * MUL_W;
  localparam int ACC_W      = PROD_W + 1;
  localparam int PERIOD_W   = 24;
  localparam int LIMIT_W    = 31;
  localparam int FRAC_W     = 16;
  localparam int INC_W      = 34;
  localparam int ISUM_W     = INC_W + 1;
  localparam int HI_W       = ACC_W - FRAC_W;
  localparam int CFG_IDX_W  = 3;

  typedef logic [CFG_IDX_W-1:0] reg_idx_t;

  localparam reg_idx_t REG_GAIN_SPEED     = 3'd0;
  localparam reg_idx_t REG_GAIN_TILT      = 3'd1;
  localparam reg_idx_t REG_GAIN_TILT_RATE = 3'd2;
  localparam reg_idx_t REG_GAIN_INTEGRAL  = 3'd3;
  localparam reg_idx_t REG_SAMPLE_PERIOD  = 3'd4;
  localparam reg_idx_t REG_TILT_LIMIT     = 3'd5;
  localparam reg_idx_t REG_OUTPUT_LIMIT   = 3'd6;
  localparam reg_idx_t REG_INTEGRAL_LIMIT = 3'd7;

  localparam logic signed [DATA_W-1:0] RST_GAIN_SPEED     = -32'sd122913;
  localparam logic signed [DATA_W-1:0] RST_GAIN_TILT      = -32'sd1917465;
  localparam logic signed [DATA_W-1:0] RST_GAIN_TILT_RATE = -32'sd59769;
  localparam logic signed [DATA_W-1:0] RST_GAIN_INTEGRAL  = 32'sd30776;
  localparam logic [PERIOD_W-1:0]      RST_SAMPLE_PERIOD  = 24'd83886;
  localparam logic [LIMIT_W-1:0]       RST_TILT_LIMIT     = 31'd9151;
  localparam logic [LIMIT_W-1:0]       RST_OUTPUT_LIMIT   = 31'd13107;
  localparam logic [LIMIT_W-1:0]       RST_INTEGRAL_LIMIT = 31'd32768;

  typedef struct packed {
    logic signed [DATA_W-1:0] gain_speed;
    logic signed [DATA_W-1:0] gain_tilt;
    logic signed [DATA_W-1:0] gain_tilt_rate;
    logic signed [DATA_W-1:0] gain_integral;
    logic [PERIOD_W-1:0]      sample_period;
    logic [LIMIT_W-1:0]       tilt_limit;
    logic [LIMIT_W-1:0]       output_limit;
    logic [LIMIT_W-1:0]       integral_limit;
  } cfg_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CHECK,
    ST_INC_MUL,
    ST_INTEG,
    ST_MAC1,
    ST_MAC2,
    ST_MAC3,
    ST_MAC4,
    ST_SAT
  } state_t;

endpackage

[design/lqrbc_cfg.sv]
// ----------------------------------------------------------------------------
// LQR balance control register file
// Holds gains, sample period and limits; written through the config channel.
// ----------------------------------------------------------------------------
module lqrbc_cfg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  lqrbc_pkg::reg_idx_t           cfg_index,
  input  logic [lqrbc_pkg::DATA_W-1:0]  cfg_data,
  output lqrbc_pkg::cfg_t               cfg
);

  lqrbc_pkg::cfg_t cfg_r;
  lqrbc_pkg::cfg_t cfg_nxt;

  assign cfg_ready = 1'b1;
  assign cfg       = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid) begin
      case (cfg_index)
        lqrbc_pkg::REG_GAIN_SPEED:     cfg_nxt.gain_speed     = $signed(cfg_data);
        lqrbc_pkg::REG_GAIN_TILT:      cfg_nxt.gain_tilt      = $signed(cfg_data);
        lqrbc_pkg::REG_GAIN_TILT_RATE: cfg_nxt.gain_tilt_rate = $signed(cfg_data);
        lqrbc_pkg::REG_GAIN_INTEGRAL:  cfg_nxt.gain_integral  = $signed(cfg_data);
        lqrbc_pkg::REG_SAMPLE_PERIOD:
          cfg_nxt.sample_period  = cfg_data[lqrbc_pkg::PERIOD_W-1:0];
        lqrbc_pkg::REG_TILT_LIMIT:
          cfg_nxt.tilt_limit     = cfg_data[lqrbc_pkg::LIMIT_W-1:0];
        lqrbc_pkg::REG_OUTPUT_LIMIT:
          cfg_nxt.output_limit   = cfg_data[lqrbc_pkg::LIMIT_W-1:0];
        lqrbc_pkg::REG_INTEGRAL_LIMIT:
          cfg_nxt.integral_limit = cfg_data[lqrbc_pkg::LIMIT_W-1:0];
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.gain_speed     <= lqrbc_pkg::RST_GAIN_SPEED;
      cfg_r.gain_tilt      <= lqrbc_pkg::RST_GAIN_TILT;
      cfg_r.gain_tilt_rate <= lqrbc_pkg::RST_GAIN_TILT_RATE;
      cfg_r.gain_integral  <= lqrbc_pkg::RST_GAIN_INTEGRAL;
      cfg_r.sample_period  <= lqrbc_pkg::RST_SAMPLE_PERIOD;
      cfg_r.tilt_limit     <= lqrbc_pkg::RST_TILT_LIMIT;
      cfg_r.output_limit   <= lqrbc_pkg::RST_OUTPUT_LIMIT;
      cfg_r.integral_limit <= lqrbc_pkg::RST_INTEGRAL_LIMIT;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

[design/lqrbc_mul.sv]
// ----------------------------------------------------------------------------
// LQR balance control shared multiplier
// Registered signed 33x33 multiply, reused for every product of an item.
// ----------------------------------------------------------------------------
module lqrbc_mul (
  input  logic                                 clk,
  input  logic signed [lqrbc_pkg::MUL_W-1:0]   op_a,
  input  logic signed [lqrbc_pkg::MUL_W-1:0]   op_b,
  output logic signed [lqrbc_pkg::PROD_W-1:0]  prod_r
);

  always_ff @(posedge clk) begin
    prod_r <= lqrbc_pkg::PROD_W'(op_a) * lqrbc_pkg::PROD_W'(op_b);
  end

endmodule

[design/lqrbc_core.sv]
// ----------------------------------------------------------------------------
// LQR balance control sequencer and datapath
// Steps one item through tilt check, integral update and four-term MAC.
// ----------------------------------------------------------------------------
module lqrbc_core (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  lqrbc_pkg::cfg_t                      cfg,
  input  logic                                 in_tvalid,
  output logic                                 in_tready,
  input  logic [4*lqrbc_pkg::DATA_W-1:0]       in_tdata,
  input  logic                                 in_tuser,
  output logic                                 out_tvalid,
  input  logic                                 out_tready,
  output logic [lqrbc_pkg::DATA_W-1:0]         out_tdata,
  output logic                                 out_tuser,
  output logic signed [lqrbc_pkg::MUL_W-1:0]   mul_a,
  output logic signed [lqrbc_pkg::MUL_W-1:0]   mul_b,
  input  logic signed [lqrbc_pkg::PROD_W-1:0]  prod
);

  localparam int DW = lqrbc_pkg::DATA_W;

  lqrbc_pkg::state_t state_r, state_nxt;

  logic signed [DW-1:0]               speed_r, tilt_r, rate_r, target_r;
  logic signed [DW-1:0]               speed_nxt, tilt_nxt, rate_nxt, target_nxt;
  logic signed [lqrbc_pkg::ERR_W-1:0] err_r, err_nxt;
  logic signed [DW-1:0]               integ_r, integ_nxt;
  logic signed [lqrbc_pkg::ACC_W-1:0] acc_r, acc_nxt;
  logic                               cut_r, cut_nxt;
  logic                               out_valid_r, out_valid_nxt;
  logic [DW-1:0]                      out_drive_r, out_drive_nxt;
  logic                               out_active_r, out_active_nxt;

  logic [DW:0]                         abs_tilt;
  logic signed [lqrbc_pkg::PROD_W-1:0] inc_shift;
  logic signed [lqrbc_pkg::INC_W-1:0]  inc;
  logic signed [lqrbc_pkg::ISUM_W-1:0] isum, ilim;
  logic signed [lqrbc_pkg::ACC_W-1:0]  acc_shift;
  logic signed [lqrbc_pkg::HI_W-1:0]   hi;
  logic signed [lqrbc_pkg::HI_W:0]     neg, olim;
  logic signed [DW-1:0]                drive_sat;
  logic                                slot_free;

  assign in_tready  = (state_r == lqrbc_pkg::ST_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_drive_r;
  assign out_tuser  = out_active_r;
  assign slot_free  = !out_valid_r || out_tready;

  always_comb begin
    abs_tilt  = tilt_r[DW-1] ? (DW+1)'(-$signed({tilt_r[DW-1], tilt_r}))
                             : {1'b0, tilt_r};
    inc_shift = prod >>> 24;
    inc       = inc_shift[lqrbc_pkg::INC_W-1:0];
    isum      = lqrbc_pkg::ISUM_W'(inc) + lqrbc_pkg::ISUM_W'(integ_r);
    ilim      = $signed({4'b0, cfg.integral_limit});
    acc_shift = acc_r >>> lqrbc_pkg::FRAC_W;
    hi        = acc_shift[lqrbc_pkg::HI_W-1:0];
    neg       = -((lqrbc_pkg::HI_W+1)'(hi));
    olim      = $signed({{(lqrbc_pkg::HI_W+1-lqrbc_pkg::LIMIT_W){1'b0}}, cfg.output_limit});
    if (neg > olim) begin
      drive_sat = DW'(olim);
    end else if (neg < -olim) begin
      drive_sat = DW'(-olim);
    end else begin
      drive_sat = neg[DW-1:0];
    end
  end

  always_comb begin
    state_nxt      = state_r;
    speed_nxt      = speed_r;
    tilt_nxt       = tilt_r;
    rate_nxt       = rate_r;
    target_nxt     = target_r;
    err_nxt        = err_r;
    integ_nxt      = integ_r;
    acc_nxt        = acc_r;
    cut_nxt        = cut_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_drive_nxt  = out_drive_r;
    out_active_nxt = out_active_r;
    mul_a          = '0;
    mul_b          = '0;
    case (state_r)
      lqrbc_pkg::ST_IDLE: begin
        if (in_tvalid) begin
          speed_nxt  = $signed(in_tdata[DW-1:0]);
          tilt_nxt   = $signed(in_tdata[2*DW-1:DW]);
          rate_nxt   = $signed(in_tdata[3*DW-1:2*DW]);
          target_nxt = $signed(in_tdata[4*DW-1:3*DW]);
          if (in_tuser) begin
            state_nxt = lqrbc_pkg::ST_CHECK;
          end
        end
      end
      lqrbc_pkg::ST_CHECK: begin
        err_nxt = lqrbc_pkg::ERR_W'(speed_r) - lqrbc_pkg::ERR_W'(target_r);
        if (abs_tilt > {2'b0, cfg.tilt_limit}) begin
          cut_nxt   = 1'b1;
          integ_nxt = '0;
          state_nxt = lqrbc_pkg::ST_SAT;
        end else begin
          cut_nxt   = 1'b0;
          state_nxt = lqrbc_pkg::ST_INC_MUL;
        end
      end
      lqrbc_pkg::ST_INC_MUL: begin
        mul_a     = err_r;
        mul_b     = $signed({9'b0, cfg.sample_period});
        state_nxt = lqrbc_pkg::ST_INTEG;
      end
      lqrbc_pkg::ST_INTEG: begin
        if (isum > ilim) begin
          integ_nxt = DW'(ilim);
        end else if (isum < -ilim) begin
          integ_nxt = DW'(-ilim);
        end else begin
          integ_nxt = isum[DW-1:0];
        end
        mul_a     = lqrbc_pkg::MUL_W'(cfg.gain_speed);
        mul_b     = err_r;
        state_nxt = lqrbc_pkg::ST_MAC1;
      end
      lqrbc_pkg::ST_MAC1: begin
        acc_nxt   = lqrbc_pkg::ACC_W'(prod);
        mul_a     = lqrbc_pkg::MUL_W'(cfg.gain_tilt);
        mul_b     = lqrbc_pkg::MUL_W'(tilt_r);
        state_nxt = lqrbc_pkg::ST_MAC2;
      end
      lqrbc_pkg::ST_MAC2: begin
        acc_nxt   = acc_r + lqrbc_pkg::ACC_W'(prod);
        mul_a     = lqrbc_pkg::MUL_W'(cfg.gain_tilt_rate);
        mul_b     = lqrbc_pkg::MUL_W'(rate_r);
        state_nxt = lqrbc_pkg::ST_MAC3;
      end
      lqrbc_pkg::ST_MAC3: begin
        acc_nxt   = acc_r + lqrbc_pkg::ACC_W'(prod);
        mul_a     = lqrbc_pkg::MUL_W'(cfg.gain_integral);
        mul_b     = lqrbc_pkg::MUL_W'(integ_r);
        state_nxt = lqrbc_pkg::ST_MAC4;
      end
      lqrbc_pkg::ST_MAC4: begin
        acc_nxt   = acc_r + lqrbc_pkg::ACC_W'(prod);
        state_nxt = lqrbc_pkg::ST_SAT;
      end
      lqrbc_pkg::ST_SAT: begin
        if (slot_free) begin
          out_valid_nxt  = 1'b1;
          out_drive_nxt  = cut_r ? '0 : drive_sat;
          out_active_nxt = !cut_r;
          state_nxt      = lqrbc_pkg::ST_IDLE;
        end
      end
      default: state_nxt = lqrbc_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lqrbc_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
      integ_r     <= '0;
      cut_r       <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      integ_r     <= integ_nxt;
      cut_r       <= cut_nxt;
    end
  end

  always_ff @(posedge clk) begin
    speed_r      <= speed_nxt;
    tilt_r       <= tilt_nxt;
    rate_r       <= rate_nxt;
    target_r     <= target_nxt;
    err_r        <= err_nxt;
    acc_r        <= acc_nxt;
    out_drive_r  <= out_drive_nxt;
    out_active_r <= out_active_nxt;
  end

endmodule

[design/lqr_balance_control_with_integral_unit.sv]
// ----------------------------------------------------------------------------
// LQR balance control with integral action
// Usage:
//   in_*   : one control tick per item. in_tdata carries speed, tilt, tilt_rate
//            and speed_target; in_tuser is the sample-valid flag. A tick with
//            the flag low is consumed with no result and no state change.
//   out_*  : one result per valid tick; out_tdata is the drive command,
//            out_tuser is high while the loop runs, low on tilt cutoff.
//   cfg_*  : register writes by index, taken every cycle; write only while
//            no item is in flight.
// Timing: a valid tick steps through check, increment multiply, integral update,
//   four MAC steps and saturation (only check and saturation on tilt cutoff),
//   using five passes through the single shared 33x33 multiplier. in_tready is
//   high again in the cycle the result is loaded; no tick is taken before then.
// Stall: a finished result waits in the output register; a following item
//   is accepted and worked on, and holds in its last step until that
//   register is taken.
// Reset: registers return to their defaults, the speed-error integral clears
//   and no result is pending.
// ----------------------------------------------------------------------------
module lqr_balance_control_with_integral_unit (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  input  logic [4*lqrbc_pkg::DATA_W-1:0]        in_tdata,   // speed, tilt, tilt_rate, speed_target
  input  logic                                  in_tuser,   // sample_valid
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  output logic [lqrbc_pkg::DATA_W-1:0]          out_tdata,  // drive
  output logic                                  out_tuser,  // active
  input  logic                                  cfg_valid,
  output logic                                  cfg_ready,
  input  lqrbc_pkg::reg_idx_t                   cfg_index,
  input  logic [lqrbc_pkg::DATA_W-1:0]          cfg_data
);

  lqrbc_pkg::cfg_t                      cfg;
  logic signed [lqrbc_pkg::MUL_W-1:0]   mul_a, mul_b;
  logic signed [lqrbc_pkg::PROD_W-1:0]  prod;

  lqrbc_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  lqrbc_mul u_mul (
    .clk    (clk),
    .op_a   (mul_a),
    .op_b   (mul_b),
    .prod_r (prod)
  );

  lqrbc_core u_core (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .mul_a      (mul_a),
    .mul_b      (mul_b),
    .prod       (prod)
  );

`ifndef ASSERT_OFF
  a_cutoff_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata == '0)
    else $error("cutoff result with nonzero drive");

  a_drive_limit: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |->
      ($signed(out_tdata) <= $signed({1'b0, cfg.output_limit})) &&
      ($signed(out_tdata) >= -$signed({1'b0, cfg.output_limit})))
    else $error("drive outside output limit");

  a_skip_invalid: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && !in_tuser |=> in_tready)
    else $error("invalid sample started work");

  a_busy_valid: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser |=> !in_tready)
    else $error("valid sample did not start work");
`endif

endmodule
